// ----- src/swg_pkg.sv -----
package swg_pkg;

  // Table and phase geometry
  localparam int SINE_ADDR_BITS = 10;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_N         = 1 << SINE_ADDR_BITS;
  localparam int ALIGN_UP       = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int ALIGN_DN       = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = 2;

  // Quarter turn in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [PHASE_BITS-1:0]     phase_t;
  typedef logic [SINE_ADDR_BITS:0]   sine_idx_t;
  typedef logic [15:0]               sine_word_t;
  typedef sine_word_t                sine_tab_t [0:SINE_N];

  // Register map, by word index
  typedef enum logic [1:0] {
    REG_PHASE_INC  = 2'd0,
    REG_PHASE_OFS  = 2'd1,
    REG_AMP_GAIN   = 2'd2,
    REG_OFS_LEVEL  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        phase_increment;
    logic [31:0]        phase_offset;
    logic signed [15:0] amplitude_gain;
    logic signed [23:0] offset_level;
  } cfg_t;

  // Table lookup request handed from front to back
  typedef struct packed {
    logic      neg;
    sine_idx_t idx;
  } sine_req_t;

  // Bring a 32-bit fraction of a turn to the phase width
  function automatic phase_t align_phase(input logic [31:0] v);
    logic [31:0] s;
    s = v >> ALIGN_DN;
    return phase_t'(s) << ALIGN_UP;
  endfunction

  // Q15 sine of a Q30 angle in [0, pi/2] by truncated Taylor terms
  function automatic sine_word_t sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return sine_word_t'(sum);
  endfunction

  // Quarter-wave table, entries 0..SINE_N, built at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   t;
    logic [63:0] x;
    for (int i = 0; i <= SINE_N; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_ADDR_BITS;
      t[i] = sine_q15(x);
    end
    return t;
  endfunction

endpackage

// ----- src/swg_if.sv -----
// Tick channel: one transaction asks for one sample
interface swg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Wave channel: one transaction carries one sample
interface swg_wave_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- src/sine_wave_generator.sv -----
// Channel  Role    Payload
// tick     sink    restart (1 bit)
// wave     source  sample (24 bit signed, 12 fractional bits)
// apb      slave   phase_increment @0x0, phase_offset @0x4,
//                  amplitude_gain @0x8, offset_level @0xC
//
// One sample per clock sustained while the output is not stalled; a tick is
// queued, then passes the table read, multiply, round and saturate stages.
// The single read port of the quarter-wave table sets one lookup per cycle.
// A four-entry queue lets the phase front keep taking ticks while the output
// is stalled; tick ready drops only when that queue is full.
// Synchronous reset clears the running phase, queue and stage valid bits and
// loads the register reset values.
module sine_wave_generator (
  input  logic        clk,
  input  logic        rst,
  swg_tick_if.sink    tick,
  swg_wave_if.source  wave,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  swg_pkg::cfg_t      cfg;
  logic               q_full;
  logic               q_push;
  swg_pkg::sine_req_t q_data;
  logic               q_pop;
  logic               q_valid;
  swg_pkg::sine_req_t q_head;

  swg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  swg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  swg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .wave       (wave)
  );

endmodule

// ----- src/swg_cfg.sv -----
module swg_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output swg_pkg::cfg_t cfg
);

  swg_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = swg_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_increment <= '0;
      cfg.phase_offset    <= '0;
      cfg.amplitude_gain  <= 16'sd4096;
      cfg.offset_level    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        swg_pkg::REG_PHASE_INC: cfg.phase_increment <= pwdata;
        swg_pkg::REG_PHASE_OFS: cfg.phase_offset    <= pwdata;
        swg_pkg::REG_AMP_GAIN:  cfg.amplitude_gain  <= pwdata[15:0];
        swg_pkg::REG_OFS_LEVEL: cfg.offset_level    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      swg_pkg::REG_PHASE_INC: prdata = cfg.phase_increment;
      swg_pkg::REG_PHASE_OFS: prdata = cfg.phase_offset;
      swg_pkg::REG_AMP_GAIN:  prdata = {16'd0, cfg.amplitude_gain};
      swg_pkg::REG_OFS_LEVEL: prdata = {8'd0, cfg.offset_level};
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- src/swg_front.sv -----
module swg_front (
  input  logic               clk,
  input  logic               rst,
  input  swg_pkg::cfg_t      cfg,
  swg_tick_if.sink           tick,
  input  logic               q_full,
  output logic               q_push,
  output swg_pkg::sine_req_t q_data
);

  swg_pkg::phase_t phase_accum;
  swg_pkg::phase_t base;
  swg_pkg::phase_t ph;
  logic [1:0]      quad;
  logic [swg_pkg::SINE_ADDR_BITS-1:0] addr;

  assign tick.ready = !q_full;
  assign q_push     = tick.valid && !q_full;

  // Form the phase of this tick and split it into quadrant and table index
  always_comb begin
    base = tick.restart ? '0 : phase_accum;
    ph   = base + swg_pkg::align_phase(cfg.phase_offset);
    quad = ph[swg_pkg::PHASE_BITS-1 -: 2];
    addr = ph[swg_pkg::PHASE_BITS-3 -: swg_pkg::SINE_ADDR_BITS];
    q_data.neg = quad[1];
    if (quad[0]) begin
      q_data.idx = swg_pkg::sine_idx_t'(swg_pkg::SINE_N) - {1'b0, addr};
    end else begin
      q_data.idx = {1'b0, addr};
    end
  end

  // Advance the running phase on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
    end else if (q_push) begin
      phase_accum <= base + swg_pkg::align_phase(cfg.phase_increment);
    end
  end

endmodule

// ----- src/swg_fifo.sv -----
module swg_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  swg_pkg::sine_req_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output swg_pkg::sine_req_t head_data
);

  localparam int CNT_BITS = swg_pkg::FIFO_PTR_BITS + 1;

  swg_pkg::sine_req_t                mem [swg_pkg::FIFO_DEPTH];
  logic [swg_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [swg_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0]               count;
  logic                              do_pop;

  assign full       = (count == CNT_BITS'(swg_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/swg_back.sv -----
module swg_back (
  input  logic               clk,
  input  logic               rst,
  input  swg_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  swg_pkg::sine_req_t head_data,
  output logic               pop,
  swg_wave_if.source         wave
);

  localparam swg_pkg::sine_tab_t SINE_TAB = swg_pkg::build_sine_tab();

  logic                s1_valid;
  logic                s1_neg;
  swg_pkg::sine_word_t s1_rom;
  logic                s2_valid;
  logic signed [32:0]  s2_prod;
  logic                adv;
  logic signed [16:0]  sine_val;
  logic signed [32:0]  prod_next;
  logic signed [17:0]  scaled;
  logic signed [24:0]  sum;
  logic signed [23:0]  sample_next;

  // Move the whole pipe unless the output slot is held
  assign adv = !wave.valid || wave.ready;
  assign pop = adv && head_valid;

  // Sign the table value and scale by the gain
  always_comb begin
    sine_val = $signed({1'b0, s1_rom});
    if (s1_neg) begin
      sine_val = -sine_val;
    end
    prod_next = 33'(cfg.amplitude_gain) * 33'(sine_val);
  end

  // Round, add bias and saturate
  always_comb begin
    scaled = 18'((s2_prod + 33'sd16384) >>> 15);
    sum    = 25'(scaled) + 25'(cfg.offset_level);
    if (sum > 25'sd8388607) begin
      sample_next = 24'sh7fffff;
    end else if (sum < -25'sd8388608) begin
      sample_next = 24'sh800000;
    end else begin
      sample_next = 24'(sum);
    end
  end

  // Table read, multiply and output stages
  always_ff @(posedge clk) begin
    if (adv) begin
      if (head_valid) begin
        s1_rom <= SINE_TAB[head_data.idx];
        s1_neg <= head_data.neg;
      end
      s2_prod     <= prod_next;
      wave.sample <= sample_next;
    end
  end

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      wave.valid <= 1'b0;
    end else if (adv) begin
      s1_valid   <= head_valid;
      s2_valid   <= s1_valid;
      wave.valid <= s2_valid;
    end
  end

endmodule

// ----- src/swg_checker.sv -----
module swg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_sample
);

  // Queue plus three stages bound the transactions in flight
  localparam logic [3:0] MAX_PENDING = 4'd7;

  logic [3:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count ticks taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (!in_acc && out_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("wave transaction changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("sample without a pending tick");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= MAX_PENDING)
    else $error("more ticks in flight than the pipe holds");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("wave valid right after reset");

endmodule

bind sine_wave_generator swg_checker u_swg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (tick.valid),
  .in_ready   (tick.ready),
  .out_valid  (wave.valid),
  .out_ready  (wave.ready),
  .out_sample (wave.sample)
);

// ----- tb/swg_sample_checker.sv -----
`timescale 1ns / 100ps

// Watch the tick, wave and register channels, predict every sample and compare
module swg_sample_checker (
  input  logic        clk,
  input  logic        rst,
  swg_tick_if         tick,
  swg_wave_if         wave,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);

  // Mirror of the register file and the running phase
  logic [31:0]        phase_inc;
  logic [31:0]        phase_ofs;
  logic signed [15:0] amp_gain;
  logic signed [23:0] ofs_level;
  swg_pkg::phase_t    accum;

  // Quarter-wave magnitudes, Q15
  int sine_rom [0:swg_pkg::SINE_N];

  // Samples still owed by the block, oldest first
  logic signed [23:0] sample_q [$];

  // Q15 sine of a Q30 angle in [0, pi/2], truncated Taylor terms up to x^15
  function automatic int taylor_sine_q15(input longint unsigned ang);
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    sq   = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * sq) >> 30) / longint'(2 * k * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return int'(acc);
  endfunction

  // Bring a 32-bit fraction of a turn to the phase width
  function automatic swg_pkg::phase_t align_turn(input logic [31:0] v);
    return swg_pkg::phase_t'((64'(v) >> swg_pkg::ALIGN_DN) << swg_pkg::ALIGN_UP);
  endfunction

  // Scale the looked-up sine, add the bias and saturate to 24 bits
  function automatic logic signed [23:0] sine_sample(input swg_pkg::phase_t ph);
    logic [1:0]                         quad;
    logic [swg_pkg::SINE_ADDR_BITS-1:0] a;
    int                                 mag;
    longint                             prod;
    longint                             sum;
    quad = ph[swg_pkg::PHASE_BITS-1 -: 2];
    a    = ph[swg_pkg::PHASE_BITS-3 -: swg_pkg::SINE_ADDR_BITS];
    mag  = quad[0] ? sine_rom[swg_pkg::SINE_N - int'(a)] : sine_rom[int'(a)];
    if (quad[1]) begin
      mag = -mag;
    end
    prod = longint'(amp_gain) * longint'(mag);
    sum  = ((prod + 16384) >>> 15) + longint'(ofs_level);
    if (sum > 8388607) begin
      sum = 8388607;
    end
    if (sum < -8388608) begin
      sum = -8388608;
    end
    return sum[23:0];
  endfunction

  // Fill the table once
  initial begin
    for (int i = 0; i <= swg_pkg::SINE_N; i++) begin
      sine_rom[i] = taylor_sine_q15(
        (swg_pkg::HALF_PI_Q30 * 64'(i)) >> swg_pkg::SINE_ADDR_BITS);
    end
  end

  always @(posedge clk) begin
    swg_pkg::phase_t    ph;
    logic signed [23:0] want;
    if (rst) begin
      phase_inc  = '0;
      phase_ofs  = '0;
      amp_gain   = 16'sd4096;
      ofs_level  = '0;
      accum      = '0;
      sample_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (swg_pkg::reg_idx_t'(paddr[3:2]))
          swg_pkg::REG_PHASE_INC: begin
            phase_inc = pwdata;
          end
          swg_pkg::REG_PHASE_OFS: begin
            phase_ofs = pwdata;
          end
          swg_pkg::REG_AMP_GAIN: begin
            amp_gain = pwdata[15:0];
          end
          swg_pkg::REG_OFS_LEVEL: begin
            ofs_level = pwdata[23:0];
          end
        endcase
      end

      // Compare each wave transaction with the oldest owed sample
      if (wave.valid && wave.ready) begin
        if (sample_q.size() == 0) begin
          $display("%0t: sample with no tick waiting, expected none, got %0d",
                   $realtime, wave.sample);
          mismatches++;
        end else begin
          want = sample_q.pop_front();
          if (wave.sample !== want) begin
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $realtime, want, wave.sample);
            mismatches++;
          end
        end
      end

      // Form the sample for each tick transaction, then advance the phase
      if (tick.valid && tick.ready) begin
        if (tick.restart) begin
          accum = '0;
        end
        ph = accum + align_turn(phase_ofs);
        sample_q.push_back(sine_sample(ph));
        accum = accum + align_turn(phase_inc);
      end
      pending = sample_q.size();
    end
  end

endmodule

// ----- tb/tb_sine_wave_generator.sv -----
`timescale 1ns / 100ps

module tb_sine_wave_generator;

  localparam int LATENCY     = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int TICK_TARGET = 1400;

  typedef enum {RX_OPEN, RX_HOLD, RX_JITTER} rx_mode_t;

  typedef struct {
    logic [31:0] inc;
    logic [31:0] ofs;
    logic [15:0] gain;
    logic [23:0] bias;
    int          n_ticks;
    logic [7:0]  restart_at;
  } wave_setup_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;
  int          idle_cycles;
  int          burst_left;
  rx_mode_t    rx_mode;
  int          rx_left;

  swg_tick_if tick_ch ();
  swg_wave_if wave_ch ();

  sine_wave_generator i_dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .wave    (wave_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swg_sample_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick_ch),
    .wave       (wave_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the wave output on a pattern of open, held and jittery stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(1, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        wave_ch.ready <= 1'b1;
      end
      RX_HOLD: begin
        wave_ch.ready <= 1'b0;
      end
      default: begin
        wave_ch.ready <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  // Drop the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (wave_ch.valid && wave_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(input swg_pkg::reg_idx_t r, input logic [31:0] d);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold ticks, drain the block, then load all four registers
  task automatic apply_setup(input wave_setup_t s);
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    apb_write(swg_pkg::REG_PHASE_INC, s.inc);
    apb_write(swg_pkg::REG_PHASE_OFS, s.ofs);
    // Put noise in the unused upper bits
    apb_write(swg_pkg::REG_AMP_GAIN, {16'($urandom), s.gain});
    apb_write(swg_pkg::REG_OFS_LEVEL, {8'($urandom), s.bias});
  endtask

  // Offer one tick transaction, sometimes inserting a gap between bursts
  task automatic send_tick(input logic r);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 60);
      if (gap > 0) begin
        @(negedge clk);
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'($urandom_range(0, 1));
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    tick_ch.valid   <= 1'b1;
    tick_ch.restart <= r;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  function automatic wave_setup_t random_setup();
    wave_setup_t s;
    case ($urandom_range(0, 5))
      0: s.inc = 32'h0000_0000;
      1: s.inc = 32'hFFFF_FFFF;
      // walk the table a few entries per tick
      2: s.inc = 32'($urandom_range(1, 8)) << 20;
      3: s.inc = $urandom_range(0, 32'h000F_FFFF);
      default: s.inc = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0: s.ofs = 32'h0000_0000;
      1: s.ofs = 32'hFFFF_FFFF;
      2: s.ofs = 32'h8000_0000;
      default: s.ofs = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: s.gain = 16'h8000;
      1: s.gain = 16'h7FFF;
      2: s.gain = 16'h0000;
      3: s.gain = 16'h1000;
      default: s.gain = 16'($urandom);
    endcase
    // bias near either rail lets the sum saturate
    case ($urandom_range(0, 6))
      0: s.bias = 24'h80_0000;
      1: s.bias = 24'h7F_FFFF;
      2: s.bias = 24'(8388607 - $urandom_range(0, 40000));
      3: s.bias = 24'(-8388608 + $urandom_range(0, 40000));
      4: s.bias = 24'h00_0000;
      default: s.bias = 24'($urandom);
    endcase
    s.n_ticks    = $urandom_range(40, 160);
    s.restart_at = '0;
    return s;
  endfunction

  initial begin
    wave_setup_t fixed_setups [4];
    wave_setup_t s;
    int          sent;
    clk             = 1'b0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    tick_ch.valid   = 1'b0;
    tick_ch.restart = 1'b0;
    wave_ch.ready   = 1'b0;
    idle_cycles     = 0;
    burst_left      = 0;
    rx_left         = 0;
    sent            = 0;

    // Quarter-turn steps at full positive gain, with a restart on the third tick
    fixed_setups[0] = '{32'h4000_0000, 32'h0000_0000, 16'h7FFF, 24'h00_0000, 5, 8'b0000_0100};
    // Largest step and offset, most negative gain, top bias: saturate high
    fixed_setups[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 24'h7F_FFFF, 4, 8'b0000_0001};
    // One table entry per tick from half a turn, bottom bias: saturate low
    fixed_setups[2] = '{32'h0010_0000, 32'h8000_0000, 16'h7FFF, 24'h80_0000, 4, 8'b0000_0000};
    // Offset at the last index of a quadrant, quarter-turn steps, gain and bias of minus one
    fixed_setups[3] = '{32'h4000_0000, 32'h3FF0_0000, 16'hFFFF, 24'hFF_FFFF, 4, 8'b0000_1000};

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Reset register values, with a restart in the middle
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    sent = 3;

    foreach (fixed_setups[i]) begin
      apply_setup(fixed_setups[i]);
      for (int k = 0; k < fixed_setups[i].n_ticks; k++) begin
        send_tick(fixed_setups[i].restart_at[k]);
        sent++;
      end
    end

    // Random settings, each for a run of ticks with occasional restarts
    while (sent < TICK_TARGET) begin
      s = random_setup();
      apply_setup(s);
      for (int k = 0; k < s.n_ticks; k++) begin
        send_tick($urandom_range(0, 15) == 0);
        sent++;
      end
    end

    // Drain and let any stray sample show up
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
